FILE: hw/rtl/scsa_pkg.sv
// Shared constants, codes and types of the size-class slot allocator.
`default_nettype none

package scsa_pkg;

    // Geometry
    localparam int NUM_BINS      = 6;
    localparam int SLOTS_PER_BIN = 64;
    localparam int RING_LEN      = SLOTS_PER_BIN + 1;
    localparam int CAP_REGS      = 6;

    // Field widths
    localparam int CAP_W      = 32;
    localparam int BIN_W      = 3;
    localparam int SLOT_W     = 6;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int HEAD_W     = $clog2(RING_LEN + 1);
    localparam int BIN_IDX_W  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int CAP_IDX_W  = (CAP_REGS > 1) ? $clog2(CAP_REGS) : 1;
    localparam int RAM_DEPTH  = NUM_BINS * RING_LEN;
    localparam int RAM_AW     = $clog2(RAM_DEPTH);

    // Operation codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_FIT   = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_BAD_BIN  = 2'd3
    } status_t;

    // Ring memory command
    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [RAM_AW-1:0] addr;
        logic [SLOT_W-1:0] wdata;
    } mem_cmd_t;

    // Outcome of one request, decided at the transfer
    typedef struct packed {
        status_t           status;
        logic [BIN_W-1:0]  gbin;
        logic              use_mem;
        logic [SLOT_W-1:0] slot_dflt;
    } dec_t;

endpackage

`default_nettype wire

FILE: hw/rtl/scsa_ifs.sv
// Channel interfaces: request, response and configuration write.
`default_nettype none

interface scsa_req_if;
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [scsa_pkg::CAP_W-1:0]   request_size;
    logic [scsa_pkg::BIN_W-1:0]   free_bin;
    logic [scsa_pkg::SLOT_W-1:0]  free_slot;

    modport source (output valid, func, request_size, free_bin, free_slot, input ready);
    modport sink   (input valid, func, request_size, free_bin, free_slot, output ready);
endinterface

interface scsa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [scsa_pkg::STATUS_W-1:0] status;
    logic [scsa_pkg::BIN_W-1:0]    granted_bin;
    logic [scsa_pkg::SLOT_W-1:0]   granted_slot;

    modport source (output valid, status, granted_bin, granted_slot, input ready);
    modport sink   (input valid, status, granted_bin, granted_slot, output ready);
endinterface

interface scsa_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [scsa_pkg::CFG_IDX_W-1:0] index;
    logic [scsa_pkg::CAP_W-1:0]     wdata;

    modport source (output valid, index, wdata, input ready);
    modport sink   (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/size_class_slot_allocator_unit.sv
// Top level of the size-class slot allocator.
//
//  channel  dir  payload                                   transfer
//  req      in   func, request_size, free_bin, free_slot   req.valid & req.ready
//  rsp      out  status, granted_bin, granted_slot         rsp.valid & rsp.ready
//  cfg      in   index, wdata (capacity registers 0..5)    cfg.valid & cfg.ready
//
// Each request is decoded and accesses the ring in the transfer cycle; the ring
// RAM's registered read data then forms the result in the output register.
// One request is in flight at a time; the output register lets the next request
// be taken while a result waits. cfg is always ready.
// Reset clears heads and fill marks; the ring RAM needs no clearing pass, as
// entries at or above a bin's fill mark read as their own index.
`default_nettype none

module size_class_slot_allocator_unit (
    input wire logic    clk,
    input wire logic    rst_n,
    scsa_req_if.sink    req,
    scsa_rsp_if.source  rsp,
    scsa_cfg_if.sink    cfg
);

    logic                        req_fire;
    logic                        s1_adv;
    scsa_pkg::mem_cmd_t          mem_cmd;
    scsa_pkg::dec_t              dec;
    logic [scsa_pkg::SLOT_W-1:0] rd_data;
    logic [scsa_pkg::SLOT_W-1:0] res_slot;

    logic                        s1_vld_reg, s1_vld_next;
    scsa_pkg::dec_t              s1_dec_reg, s1_dec_next;
    logic                        out_vld_reg, out_vld_next;
    scsa_pkg::status_t           out_status_reg, out_status_next;
    logic [scsa_pkg::BIN_W-1:0]  out_bin_reg, out_bin_next;
    logic [scsa_pkg::SLOT_W-1:0] out_slot_reg, out_slot_next;

    assign req.ready = !s1_vld_reg;
    assign req_fire  = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    // Bin control
    scsa_bin_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (req_fire),
        .func         (req.func),
        .request_size (req.request_size),
        .free_bin     (req.free_bin),
        .free_slot    (req.free_slot),
        .cfg_valid    (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_wdata    (cfg.wdata),
        .mem_cmd      (mem_cmd),
        .dec          (dec)
    );

    // Free ring storage
    scsa_ring_ram #(
        .DEPTH  (scsa_pkg::RAM_DEPTH),
        .DATA_W (scsa_pkg::SLOT_W),
        .ADDR_W (scsa_pkg::RAM_AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_cmd.wr_en),
        .rd_en   (mem_cmd.rd_en),
        .addr    (mem_cmd.addr),
        .wr_data (mem_cmd.wdata),
        .rd_data (rd_data)
    );

    // Stage 1 to output register
    assign s1_adv   = s1_vld_reg && (!out_vld_reg || rsp.ready);
    assign res_slot = s1_dec_reg.use_mem ? rd_data : s1_dec_reg.slot_dflt;

    always_comb
    begin
        s1_vld_next     = s1_vld_reg;
        s1_dec_next     = s1_dec_reg;
        out_vld_next    = out_vld_reg;
        out_status_next = out_status_reg;
        out_bin_next    = out_bin_reg;
        out_slot_next   = out_slot_reg;
        if (req_fire)
        begin
            s1_vld_next = 1'b1;
            s1_dec_next = dec;
        end
        else if (s1_adv)
        begin
            s1_vld_next = 1'b0;
        end
        if (s1_adv)
        begin
            out_vld_next    = 1'b1;
            out_status_next = s1_dec_reg.status;
            out_bin_next    = s1_dec_reg.gbin;
            out_slot_next   = res_slot;
        end
        else if (rsp.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= s1_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        s1_dec_reg     <= s1_dec_next;
        out_status_reg <= out_status_next;
        out_bin_reg    <= out_bin_next;
        out_slot_reg   <= out_slot_next;
    end

    assign rsp.valid        = out_vld_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.granted_bin  = out_bin_reg;
    assign rsp.granted_slot = out_slot_reg;

    // Checks
    a_fire_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (s1_vld_reg && !req.ready))
        else $error("accepted request did not occupy stage 1");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != scsa_pkg::ST_OK))
        |-> ((rsp.granted_bin == '0) && (rsp.granted_slot == '0)))
        else $error("failed request carries a bin or slot");

    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_vld_reg && out_vld_reg && !rsp.ready) |=> (s1_vld_reg && $stable(s1_dec_reg)))
        else $error("stage 1 lost while output stalled");

endmodule

`default_nettype wire

FILE: hw/rtl/scsa_ring_ram.sv
// Generic single-port-write, registered-read RAM holding the free rings.
`default_nettype none

module scsa_ring_ram #(
    parameter int DEPTH  = 390,
    parameter int DATA_W = 6,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [DATA_W-1:0] wr_data,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
    end

    // Registered read, held between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[addr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/scsa_bin_ctrl.sv
// Bin control: capacity registers, head table, fill marks and request decode.
`default_nettype none

module scsa_bin_ctrl (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           accept,
    input  wire logic                           func,
    input  wire logic [scsa_pkg::CAP_W-1:0]     request_size,
    input  wire logic [scsa_pkg::BIN_W-1:0]     free_bin,
    input  wire logic [scsa_pkg::SLOT_W-1:0]    free_slot,
    input  wire logic                           cfg_valid,
    input  wire logic [scsa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [scsa_pkg::CAP_W-1:0]     cfg_wdata,
    output scsa_pkg::mem_cmd_t                  mem_cmd,
    output scsa_pkg::dec_t                      dec
);

    logic [scsa_pkg::CAP_W-1:0]  cap_reg  [scsa_pkg::CAP_REGS];
    logic [scsa_pkg::HEAD_W-1:0] head_reg [scsa_pkg::NUM_BINS];
    logic [scsa_pkg::HEAD_W-1:0] head_next[scsa_pkg::NUM_BINS];
    // Fill mark: ring entries at or above the mark still hold their reset index;
    // entries between head and mark have been written back by a free
    logic [scsa_pkg::HEAD_W-1:0] mark_reg [scsa_pkg::NUM_BINS];
    logic [scsa_pkg::HEAD_W-1:0] mark_next[scsa_pkg::NUM_BINS];

    logic [scsa_pkg::NUM_BINS-1:0]  fit;
    logic                           any_fit;
    logic [scsa_pkg::BIN_IDX_W-1:0] sel;
    logic [scsa_pkg::BIN_IDX_W-1:0] fidx;
    logic                           fbin_ok;
    logic [scsa_pkg::HEAD_W-1:0]    sel_head;
    logic [scsa_pkg::HEAD_W-1:0]    free_head;

    // Capacity registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < scsa_pkg::CAP_REGS; i++)
            begin
                cap_reg[i] <= '0;
            end
        end
        else if (cfg_valid && (int'(cfg_index) < scsa_pkg::CAP_REGS))
        begin
            cap_reg[cfg_index[scsa_pkg::CAP_IDX_W-1:0]] <= cfg_wdata;
        end
    end

    // Per-bin fit: capacity large enough and ring not empty
    always_comb
    begin
        for (int b = 0; b < scsa_pkg::NUM_BINS; b++)
        begin
            fit[b] = (b < scsa_pkg::CAP_REGS) && (cap_reg[b] >= request_size)
                     && (head_reg[b] != scsa_pkg::HEAD_W'(scsa_pkg::SLOTS_PER_BIN));
        end
    end

    // First fitting bin in ascending order
    always_comb
    begin
        sel = '0;
        for (int b = scsa_pkg::NUM_BINS - 1; b >= 0; b--)
        begin
            if (fit[b])
            begin
                sel = scsa_pkg::BIN_IDX_W'(b);
            end
        end
    end

    assign any_fit   = |fit;
    assign sel_head  = head_reg[sel];
    assign fbin_ok   = (free_bin != '0) && (int'(free_bin) <= scsa_pkg::NUM_BINS);
    assign fidx      = scsa_pkg::BIN_IDX_W'(free_bin - scsa_pkg::BIN_W'(1));
    assign free_head = head_reg[fidx];

    // Decode, memory command and head/mark updates
    always_comb
    begin
        for (int b = 0; b < scsa_pkg::NUM_BINS; b++)
        begin
            head_next[b] = head_reg[b];
            mark_next[b] = mark_reg[b];
        end
        mem_cmd.rd_en  = 1'b0;
        mem_cmd.wr_en  = 1'b0;
        mem_cmd.addr   = '0;
        mem_cmd.wdata  = free_slot;
        dec.status     = scsa_pkg::ST_NO_FIT;
        dec.gbin       = '0;
        dec.use_mem    = 1'b0;
        dec.slot_dflt  = '0;
        case (func)
            scsa_pkg::FUNC_ALLOC:
            begin
                mem_cmd.addr = scsa_pkg::RAM_AW'(sel) * scsa_pkg::RAM_AW'(scsa_pkg::RING_LEN)
                               + scsa_pkg::RAM_AW'(sel_head);
                if (any_fit)
                begin
                    dec.status    = scsa_pkg::ST_OK;
                    dec.gbin      = scsa_pkg::BIN_W'(sel) + scsa_pkg::BIN_W'(1);
                    dec.use_mem   = (sel_head < mark_reg[sel]);
                    dec.slot_dflt = sel_head[scsa_pkg::SLOT_W-1:0];
                    mem_cmd.rd_en = accept;
                    if (accept)
                    begin
                        head_next[sel] = sel_head + scsa_pkg::HEAD_W'(1);
                        if (sel_head >= mark_reg[sel])
                        begin
                            mark_next[sel] = sel_head + scsa_pkg::HEAD_W'(1);
                        end
                    end
                end
            end
            scsa_pkg::FUNC_FREE:
            begin
                mem_cmd.addr = scsa_pkg::RAM_AW'(fidx) * scsa_pkg::RAM_AW'(scsa_pkg::RING_LEN)
                               + scsa_pkg::RAM_AW'(free_head - scsa_pkg::HEAD_W'(1));
                if (!fbin_ok)
                begin
                    dec.status = scsa_pkg::ST_BAD_BIN;
                end
                else if (free_head == '0)
                begin
                    dec.status = scsa_pkg::ST_OVERFLOW;
                end
                else
                begin
                    dec.status    = scsa_pkg::ST_OK;
                    mem_cmd.wr_en = accept;
                    if (accept)
                    begin
                        head_next[fidx] = free_head - scsa_pkg::HEAD_W'(1);
                    end
                end
            end
            default:
            begin
                dec.status = scsa_pkg::ST_NO_FIT;
            end
        endcase
    end

    // Head table and fill marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < scsa_pkg::NUM_BINS; b++)
            begin
                head_reg[b] <= '0;
                mark_reg[b] <= '0;
            end
        end
        else
        begin
            for (int b = 0; b < scsa_pkg::NUM_BINS; b++)
            begin
                head_reg[b] <= head_next[b];
                mark_reg[b] <= mark_next[b];
            end
        end
    end

    // Checks
    for (genvar g = 0; g < scsa_pkg::NUM_BINS; g++)
    begin : g_chk
        a_head_in_mark: assert property (@(posedge clk) disable iff (!rst_n)
            (head_reg[g] <= mark_reg[g])
            && (mark_reg[g] <= scsa_pkg::HEAD_W'(scsa_pkg::SLOTS_PER_BIN)))
            else $error("head above fill mark or mark out of range");
    end

    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_cmd.rd_en || mem_cmd.wr_en) |-> (accept && !(mem_cmd.rd_en && mem_cmd.wr_en)))
        else $error("ring access without a transfer, or read and write together");

    a_alloc_moves_head: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (func == scsa_pkg::FUNC_ALLOC) && (dec.status == scsa_pkg::ST_OK))
        |=> (head_reg[$past(sel)] == $past(sel_head) + scsa_pkg::HEAD_W'(1)))
        else $error("granted bin head did not advance");

endmodule

`default_nettype wire
